/* sv/led_panel_blink_controller_defines.svh */
// Assertion macros used by the controller RTL.
`ifndef LED_PANEL_BLINK_CONTROLLER_DEFINES_SVH
`define LED_PANEL_BLINK_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset.
`define LPB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
// Check on every clock edge, reset included.
`define LPB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");
`else
`define LPB_ASSERT(lbl, prop)
`define LPB_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* sv/lpb_pkg.sv */
`default_nettype none

package lpb_pkg;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET_IND  = 2'd1,
        OP_SHOW_NUM = 2'd2,
        OP_BLINK    = 2'd3
    } t_opcode;

    localparam logic [2:0] IND_GREEN = 3'd0;
    localparam logic [2:0] IND_RED   = 3'd1;
    localparam logic [2:0] IND_LOCK  = 3'd2;
    localparam logic [2:0] IND_PT1   = 3'd3;
    localparam logic [2:0] IND_PT2   = 3'd4;
    localparam logic [2:0] IND_MENU  = 3'd5;

    localparam logic [1:0] REG_TOGGLE_TICK = 2'd0;
    localparam logic [1:0] REG_PERIOD_END  = 2'd1;
    localparam logic [1:0] REG_REPEATS     = 2'd2;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [15:0] TOGGLE_TICK_RST = 16'd25000;
    localparam logic [15:0] PERIOD_END_RST  = 16'd50000;
    localparam logic [7:0]  REPEATS_RST     = 8'd7;

    localparam logic [7:0]  PANEL_GREEN     = 8'h02;
    localparam logic [7:0]  PANEL_RED       = 8'h80;
    localparam logic [7:0]  PANEL_LOCK      = 8'h04;
    localparam logic [7:0]  PANEL_MENU_GRN  = 8'h10;
    localparam logic [7:0]  PANEL_MENU_RED  = 8'h08;
    localparam logic [15:0] DISP_PT1        = 16'h0080;
    localparam logic [15:0] DISP_PT2        = 16'h8000;
    localparam logic [15:0] DISP_BLANK      = 16'hFFFF;
    localparam logic [6:0]  NUM_MAX         = 7'd98;

    typedef struct packed {
        t_opcode     opcode;
        logic [2:0]  indicator;
        logic        turn_on;
        logic [7:0]  number;
        logic [1:0]  blink_select;
    } t_in_req;

    typedef struct packed {
        logic [7:0]  panel_bits;
        logic [15:0] display_bits;
        logic        blink_active;
    } t_out_res;

    function automatic logic [7:0] glyph(input logic [3:0] digit);
        logic [7:0] g;
        case (digit)
            4'd0: g = 8'hc0;
            4'd1: g = 8'hf9;
            4'd2: g = 8'ha4;
            4'd3: g = 8'hb0;
            4'd4: g = 8'h99;
            4'd5: g = 8'h92;
            4'd6: g = 8'h82;
            4'd7: g = 8'hf8;
            4'd8: g = 8'h80;
            4'd9: g = 8'h90;
            default: g = 8'hff;
        endcase
        return g;
    endfunction

    function automatic logic [15:0] point_mask(input logic [1:0] sel);
        return (sel[0] ? DISP_PT1 : 16'h0000) | (sel[1] ? DISP_PT2 : 16'h0000);
    endfunction

    // Glyph pair for min(num,98)+1; tens digit by reciprocal multiply (v*205 >> 11).
    function automatic logic [15:0] number_glyphs(input logic [7:0] num);
        logic [6:0]  v;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        v     = ((num > {1'b0, NUM_MAX}) ? NUM_MAX : num[6:0]) + 7'd1;
        prod  = 15'(v) * 15'd205;
        tens  = prod[14:11];
        units = v - 7'(tens) * 7'd10;
        return {glyph(units[3:0]), glyph(tens)};
    endfunction

endpackage

`default_nettype wire

/* sv/led_panel_blink_controller.sv */
// LED panel / two-digit seven-segment blink controller.
// Input channel: i_in_valid / o_in_stall carry one command request (tick, set
// indicator, show number, start blink). Output channel: o_out_valid /
// i_out_stall carry one result per request: panel word, active-low display
// word and the blink-running flag, taken after the command is applied.
// A request is accepted on an edge with valid high and stall low. Its result
// appears in the result register (or the skid register) and stays until taken.
// Throughput is one request per cycle while o_in_stall is low: the state update
// is a single pass of logic from the accepted request into the result register.
// The output has a result register plus a one-entry skid register; when the
// receiver stalls, one more request is still taken into the skid, after which
// o_in_stall rises until the skid drains into the result register.
// Configuration goes through the APB port (toggle tick at 0x0, period end at 0x4,
// repeats at 0x8); the user must write it only while the block is idle (not enforced).
// Reset (synchronous, active low) blanks the display, clears the panel word,
// stops blinking, loads default timing and empties the output stages.
`default_nettype none
`include "led_panel_blink_controller_defines.svh"

module led_panel_blink_controller (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire lpb_pkg::t_in_req             i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output lpb_pkg::t_out_res                 o_out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lpb_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lpb_pkg::DATA_W-1:0]   pwdata,
    output logic [lpb_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    import lpb_pkg::*;

    logic [15:0] r_toggle_tick;
    logic [15:0] r_period_end;
    logic [7:0]  r_repeats;

    logic [7:0]  r_panel,    n_panel;
    logic [15:0] r_display,  n_display;
    logic [1:0]  r_flags,    n_flags;
    logic [1:0]  r_saved,    n_saved;
    logic [7:0]  r_cycle,    n_cycle;
    logic [16:0] r_tick,     n_tick;

    t_out_res r_out, r_skid;
    logic     r_out_valid, r_skid_valid;

    logic     in_accept, out_take, cfg_write;
    t_out_res result;

    assign pready     = 1'b1;
    assign cfg_write  = psel & penable & pwrite;
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid & ~r_skid_valid;
    assign out_take   = r_out_valid & ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        case (paddr[3:2])
            REG_TOGGLE_TICK: prdata = {16'h0000, r_toggle_tick};
            REG_PERIOD_END:  prdata = {16'h0000, r_period_end};
            REG_REPEATS:     prdata = {24'h000000, r_repeats};
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        n_panel   = r_panel;
        n_display = r_display;
        n_flags   = r_flags;
        n_saved   = r_saved;
        n_cycle   = r_cycle;
        n_tick    = r_tick;
        case (i_in_data.opcode)
            OP_TICK: begin
                if (r_flags != 2'b00) begin
                    if (r_cycle < r_repeats) begin
                        if (r_tick == 17'd0) begin
                            n_display = n_display & ~point_mask(r_flags);
                        end
                        if (r_tick == {1'b0, r_toggle_tick}) begin
                            n_display = n_display | point_mask(r_flags);
                        end
                        if (r_tick > {1'b0, r_period_end}) begin
                            n_tick  = '0;
                            n_cycle = r_cycle + 8'd1;
                        end else begin
                            n_tick = r_tick + 17'd1;
                        end
                    end else begin
                        // sequence done: relight the points saved at the request
                        n_cycle   = '0;
                        n_flags   = '0;
                        n_display = r_display & ~point_mask(r_saved);
                    end
                end
            end
            OP_SET_IND: begin
                case (i_in_data.indicator)
                    IND_GREEN: n_panel = i_in_data.turn_on ? (r_panel | PANEL_GREEN)
                                                           : (r_panel & ~PANEL_GREEN);
                    IND_RED:   n_panel = i_in_data.turn_on ? (r_panel | PANEL_RED)
                                                           : (r_panel & ~PANEL_RED);
                    IND_LOCK:  n_panel = i_in_data.turn_on ? (r_panel | PANEL_LOCK)
                                                           : (r_panel & ~PANEL_LOCK);
                    IND_PT1:   n_display = i_in_data.turn_on ? (r_display & ~DISP_PT1)
                                                             : (r_display | DISP_PT1);
                    IND_PT2:   n_display = i_in_data.turn_on ? (r_display & ~DISP_PT2)
                                                             : (r_display | DISP_PT2);
                    IND_MENU:  n_panel = i_in_data.turn_on
                                   ? ((r_panel | PANEL_MENU_GRN) & ~PANEL_MENU_RED)
                                   : ((r_panel | PANEL_MENU_RED) & ~PANEL_MENU_GRN);
                    default:   n_panel = r_panel;
                endcase
            end
            OP_SHOW_NUM: begin
                n_display = number_glyphs(i_in_data.number);
            end
            OP_BLINK: begin
                if (i_in_data.blink_select != 2'b00) begin
                    n_flags = r_flags | i_in_data.blink_select;
                    n_saved = {~r_display[15], ~r_display[7]};
                end
            end
            default: n_panel = r_panel;
        endcase
    end

    assign result = '{panel_bits: n_panel, display_bits: n_display,
                      blink_active: (n_flags != 2'b00)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle_tick <= TOGGLE_TICK_RST;
            r_period_end  <= PERIOD_END_RST;
            r_repeats     <= REPEATS_RST;
            r_panel       <= '0;
            r_display     <= DISP_BLANK;
            r_flags       <= '0;
            r_saved       <= '0;
            r_cycle       <= '0;
            r_tick        <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (paddr[3:2])
                    REG_TOGGLE_TICK: r_toggle_tick <= pwdata[15:0];
                    REG_PERIOD_END:  r_period_end  <= pwdata[15:0];
                    REG_REPEATS:     r_repeats     <= pwdata[7:0];
                    default:         r_repeats     <= r_repeats;
                endcase
            end
            if (in_accept) begin
                r_panel   <= n_panel;
                r_display <= n_display;
                r_flags   <= n_flags;
                r_saved   <= n_saved;
                r_cycle   <= n_cycle;
                r_tick    <= n_tick;
            end
            if (r_skid_valid) begin
                // drain the skid into the output register
                if (out_take) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_accept) begin
                if (!r_out_valid || out_take) begin
                    r_out       <= result;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= result;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `LPB_ASSERT_ALWAYS(a_skid_needs_out, r_skid_valid |-> r_out_valid)
    `LPB_ASSERT(a_stalled_result_to_skid,
                (r_out_valid && i_out_stall && in_accept) |=> r_skid_valid)
    `LPB_ASSERT(a_idle_blink_counter, (r_flags == 2'b00) |-> (r_cycle == 8'd0))
    `LPB_ASSERT(a_active_flag_matches,
                (in_accept && !r_skid_valid && !r_out_valid)
                |=> (o_out_data.blink_active == (r_flags != 2'b00)))

endmodule

`default_nettype wire
